>>> hdl/bdfr_pkg.sv
// shared types and constants for the bit destuffing frame receiver
package bdfr_pkg;

	localparam int unsigned LenW     = 11;
	localparam int unsigned ByteW    = 8;
	localparam int unsigned RunW     = 3;
	localparam int unsigned BitCntW  = 3;
	localparam logic [LenW-1:0] MaxFrameReset = LenW'(256);
	localparam logic [RunW-1:0] RunSat       = RunW'(7);
	localparam logic [RunW-1:0] RunStuff     = RunW'(5);
	localparam logic [RunW-1:0] RunFlag      = RunW'(6);
	localparam logic [BitCntW-1:0] LastBit   = BitCntW'(7);

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_DATA     = 3'd1,
		EV_DONE     = 3'd2,
		EV_ABORT    = 3'd3,
		EV_OVERFLOW = 3'd4
	} event_t;

	typedef struct packed {
		logic [RunW-1:0]    ones_run;
		logic               framing;
		logic [ByteW-1:0]   shift_byte;
		logic [BitCntW-1:0] bits_in_byte;
		logic [LenW-1:0]    byte_count;
		logic               idle_mark;
	} rx_state_t;

	typedef struct packed {
		event_t           ev;
		logic [ByteW-1:0] data_byte;
		logic [LenW-1:0]  frame_length;
		logic             in_frame;
		logic             bus_idle;
	} rx_result_t;

endpackage

>>> hdl/bit_destuffing_frame_receiver_unit.sv
// top level of the bit destuffing frame receiver
// each input transaction passes through the input register and then the result register, which drives the output
// throughput: one line bit per cycle, one result per bit, stalls only on output back-pressure
// the state update for a bit happens as it moves from the input register to the result register
// reset clears the framing state, both valid flags and sets the frame limit to 256 bytes
module bit_destuffing_frame_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,    // max_frame_bytes
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_bit, zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // data_byte, frame_length, in_frame, bus_idle, zero fill
	output logic [2:0]  m_axis_tuser    // event_res
);

	logic [bdfr_pkg::LenW-1:0] max_frame_q;
	bdfr_pkg::rx_state_t       state_q;
	bdfr_pkg::rx_state_t       state_nxt;
	bdfr_pkg::rx_result_t      res_nxt;
	bdfr_pkg::rx_result_t      res_s2;
	logic                      bit_s1;
	logic                      valid_s1;
	logic                      valid_s2;
	logic                      in_take;
	logic                      advance;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	bdfr_deframer u_deframer (
		.cur             (state_q),
		.rx_bit          (bit_s1),
		.max_frame_bytes (max_frame_q),
		.nxt             (state_nxt),
		.res             (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= bdfr_pkg::MaxFrameReset;
		end else if (cfg_wr_en) begin
			max_frame_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				state_q  <= state_nxt;
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			bit_s1 <= s_axis_tdata[0];
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.ev;
	assign m_axis_tdata  = {3'b000, res_s2.bus_idle, res_s2.in_frame,
		res_s2.frame_length, res_s2.data_byte};

	a_data_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.ev == bdfr_pkg::EV_DATA) |->
		(res_s2.in_frame && res_s2.frame_length != '0))
		else $error("data byte reported outside a frame");

	a_end_leaves_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (res_s2.ev == bdfr_pkg::EV_DONE || res_s2.ev == bdfr_pkg::EV_ABORT
		|| res_s2.ev == bdfr_pkg::EV_OVERFLOW)) |-> !res_s2.in_frame)
		else $error("frame end event while still in frame");

	a_abort_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.ev == bdfr_pkg::EV_ABORT) |-> res_s2.bus_idle)
		else $error("abort without idle bus");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without a bit moving on");

	a_no_data_off_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.framing |-> (state_q.byte_count == '0 && state_q.bits_in_byte == '0))
		else $error("assembly state left over outside a frame");

endmodule

>>> hdl/bdfr_deframer.sv
// next-state and result logic for one received line bit
module bdfr_deframer (
	input  bdfr_pkg::rx_state_t           cur,
	input  logic                          rx_bit,
	input  logic [bdfr_pkg::LenW-1:0]     max_frame_bytes,
	output bdfr_pkg::rx_state_t           nxt,
	output bdfr_pkg::rx_result_t          res
);

	logic                          ended;
	logic [bdfr_pkg::LenW-1:0]     ended_len;
	logic                          shift_in;
	logic [bdfr_pkg::ByteW-1:0]    shifted;

	always_comb begin
		nxt       = cur;
		res.ev    = bdfr_pkg::EV_NONE;
		res.data_byte = '0;
		ended     = 1'b0;
		ended_len = '0;
		shift_in  = 1'b1;
		shifted   = '0;

		if (rx_bit) begin
			if (cur.ones_run != bdfr_pkg::RunSat) begin
				nxt.ones_run = cur.ones_run + bdfr_pkg::RunW'(1);
			end else begin
				// abort pattern
				if (cur.framing) begin
					res.ev = bdfr_pkg::EV_ABORT;
				end
				ended            = 1'b1;
				ended_len        = cur.byte_count;
				nxt.framing      = 1'b0;
				nxt.idle_mark    = 1'b1;
				nxt.shift_byte   = '0;
				nxt.bits_in_byte = '0;
				nxt.byte_count   = '0;
				shift_in         = 1'b0;
			end
		end else begin
			priority if (cur.ones_run == bdfr_pkg::RunStuff) begin
				// stuffed zero
				nxt.ones_run = '0;
				shift_in     = 1'b0;
			end else if (cur.ones_run == bdfr_pkg::RunFlag) begin
				if (cur.framing && (cur.byte_count != '0)) begin
					res.ev    = bdfr_pkg::EV_DONE;
					ended     = 1'b1;
					ended_len = cur.byte_count;
				end
				nxt.framing      = ~cur.framing;
				nxt.ones_run     = '0;
				nxt.shift_byte   = '0;
				nxt.bits_in_byte = '0;
				nxt.byte_count   = '0;
				shift_in         = 1'b0;
			end else begin
				if (!cur.framing) begin
					nxt.idle_mark = 1'b0;
				end
				nxt.ones_run = '0;
			end
		end

		if (shift_in && cur.framing) begin
			shifted = {rx_bit, cur.shift_byte[bdfr_pkg::ByteW-1:1]};
			if (cur.bits_in_byte == bdfr_pkg::LastBit) begin
				nxt.shift_byte   = '0;
				nxt.bits_in_byte = '0;
				if (cur.byte_count < max_frame_bytes) begin
					nxt.byte_count = cur.byte_count + bdfr_pkg::LenW'(1);
					res.ev         = bdfr_pkg::EV_DATA;
					res.data_byte  = shifted;
				end else begin
					res.ev         = bdfr_pkg::EV_OVERFLOW;
					ended          = 1'b1;
					ended_len      = cur.byte_count;
					nxt.framing    = 1'b0;
					nxt.byte_count = '0;
				end
			end else begin
				nxt.shift_byte   = shifted;
				nxt.bits_in_byte = cur.bits_in_byte + bdfr_pkg::BitCntW'(1);
			end
		end

		res.frame_length = ended ? ended_len : nxt.byte_count;
		res.in_frame     = nxt.framing;
		res.bus_idle     = nxt.idle_mark;
	end

endmodule
